[sv/bed_pkg.sv]
// Shared types and constants of the button event detector.
// No dependencies; every other file imports this package.
package bed_pkg;

  localparam int NUM_BUTTONS = 8;
  localparam int NUM_COMBOS  = 4;
  localparam int TIME_BITS   = 32;
  localparam int BTN_W       = $clog2(NUM_BUTTONS);
  localparam int CMB_W       = (NUM_COMBOS > 1) ? $clog2(NUM_COMBOS) : 1;

  // Event codes
  localparam logic [2:0] EV_PRESS   = 3'd0;
  localparam logic [2:0] EV_RELEASE = 3'd1;
  localparam logic [2:0] EV_DOUBLE  = 3'd2;
  localparam logic [2:0] EV_TRIPLE  = 3'd3;
  localparam logic [2:0] EV_LONG    = 3'd4;
  localparam logic [2:0] EV_COMBO   = 3'd5;

  // Configuration register indexes
  localparam logic [2:0] REG_ENABLE      = 3'd0;
  localparam logic [2:0] REG_ACTIVE_HIGH = 3'd1;
  localparam logic [2:0] REG_DEBOUNCE    = 3'd2;
  localparam logic [2:0] REG_LONG_PRESS  = 3'd3;
  localparam logic [2:0] REG_LONG_REPEAT = 3'd4;
  localparam logic [2:0] REG_CLICK_GAP   = 3'd5;
  localparam logic [2:0] REG_COMBO_GAP   = 3'd6;
  localparam logic [2:0] REG_COMBO_TABLE = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BTN_DEB,
    ST_BTN_LONG,
    ST_CMB_START,
    ST_CMB_ENTRY,
    ST_CMB_KEY,
    ST_CMB_EVAL,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic             accept;
    logic             deb_step;
    logic             long_step;
    logic             entry_step;
    logic             key_step;
    logic             eval_step;
    logic             flush;
    logic [BTN_W-1:0] btn_idx;
    logic [CMB_W-1:0] cmb_idx;
    logic [1:0]       key_idx;
  } cmd_t;

  typedef struct packed {
    logic btn_en;
    logic skip_scan;
    logic entry_match;
    logic key_last;
    logic seq_fail;
    logic out_free;
  } sts_t;

endpackage

[sv/bed_ctrl.sv]
// Sequencer of the button event detector: walks buttons, then combos.
// Depends on bed_pkg.
module bed_ctrl
  import bed_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t           state, state_next;
  logic [BTN_W-1:0] btn, btn_next;
  logic [CMB_W-1:0] cmb, cmb_next;
  logic [1:0]       key, key_next;
  logic             go;

  localparam logic [BTN_W-1:0] BTN_LAST = BTN_W'(NUM_BUTTONS - 1);
  localparam logic [CMB_W-1:0] CMB_LAST = CMB_W'(NUM_COMBOS - 1);

  assign go = sts.out_free;

  // Next state and counters
  always_comb begin
    state_next = state;
    btn_next   = btn;
    cmb_next   = cmb;
    key_next   = key;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_BTN_DEB;
          btn_next   = '0;
        end
      end
      ST_BTN_DEB: begin
        if (go) begin
          if (sts.btn_en) begin
            state_next = ST_BTN_LONG;
          end else if (btn == BTN_LAST) begin
            state_next = ST_CMB_START;
          end else begin
            btn_next = btn + 1'b1;
          end
        end
      end
      ST_BTN_LONG: begin
        if (go) begin
          if (btn == BTN_LAST) begin
            state_next = ST_CMB_START;
          end else begin
            btn_next   = btn + 1'b1;
            state_next = ST_BTN_DEB;
          end
        end
      end
      ST_CMB_START: begin
        cmb_next   = '0;
        state_next = sts.skip_scan ? ST_FLUSH : ST_CMB_ENTRY;
      end
      ST_CMB_ENTRY: begin
        if (sts.entry_match) begin
          state_next = ST_CMB_KEY;
          key_next   = '0;
        end else if (cmb == CMB_LAST) begin
          state_next = ST_FLUSH;
        end else begin
          cmb_next = cmb + 1'b1;
        end
      end
      ST_CMB_KEY: begin
        if (sts.key_last) begin
          state_next = ST_CMB_EVAL;
        end else begin
          key_next = key + 1'b1;
        end
      end
      ST_CMB_EVAL: begin
        if (go) begin
          if (sts.seq_fail || cmb == CMB_LAST) begin
            state_next = ST_FLUSH;
          end else begin
            cmb_next   = cmb + 1'b1;
            state_next = ST_CMB_ENTRY;
          end
        end
      end
      ST_FLUSH: begin
        if (go) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd            = '0;
    cmd.btn_idx    = btn;
    cmd.cmb_idx    = cmb;
    cmd.key_idx    = key;
    in_ready       = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_BTN_DEB:   cmd.deb_step   = go & sts.btn_en;
      ST_BTN_LONG:  cmd.long_step  = go;
      ST_CMB_ENTRY: cmd.entry_step = 1'b1;
      ST_CMB_KEY:   cmd.key_step   = 1'b1;
      ST_CMB_EVAL:  cmd.eval_step  = go;
      ST_FLUSH:     cmd.flush      = go;
      default: ;
    endcase
  end

  // Hold state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      btn   <= '0;
      cmb   <= '0;
      key   <= '0;
    end else begin
      state <= state_next;
      btn   <= btn_next;
      cmb   <= cmb_next;
      key   <= key_next;
    end
  end

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == ST_BTN_DEB && btn == '0)
    else $error("accept did not start the button walk");
  a_long_after_deb: assert property (@(posedge clk) disable iff (rst)
    state == ST_BTN_LONG |-> $past(state) == ST_BTN_LONG || $past(state) == ST_BTN_DEB)
    else $error("long phase entered out of order");
  a_key_after_entry: assert property (@(posedge clk) disable iff (rst)
    state == ST_CMB_ENTRY && sts.entry_match |=> state == ST_CMB_KEY && key == '0)
    else $error("matched combo did not start key reads");

endmodule

[sv/bed_dp.sv]
// Datapath of the button event detector: configuration, per-button state,
// combo accumulation and the event hold/output registers. Depends on bed_pkg.
module bed_dp
  import bed_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [7:0]  button_levels,
  input  logic        cfg_valid,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  source_index,
  output logic        is_combo,
  output logic [2:0]  event_code,
  output logic        last_event
);

  // Configuration
  logic [NUM_BUTTONS-1:0] enable_mask;
  logic                   active_high;
  logic [7:0]             debounce_limit;
  logic [63:0]            long_press_table;
  logic [63:0]            long_repeat_table;
  logic [15:0]            click_gap;
  logic [15:0]            combo_gap;
  logic [63:0]            combo_table;

  // Per-button state
  logic [NUM_BUTTONS-1:0] deb_level;
  logic [7:0]             deb_count   [NUM_BUTTONS];
  logic [7:0]             long_count  [NUM_BUTTONS];
  logic [2:0]             click_count [NUM_BUTTONS];
  logic [TIME_BITS-1:0]   press_time  [NUM_BUTTONS];
  logic [TIME_BITS-1:0]   release_time[NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] pressed_mask;
  logic [TIME_BITS-1:0]   tick;
  logic [7:0]             levels;

  // Combo accumulators
  logic [TIME_BITS-1:0]   t_lo, t_hi, t_prev;
  logic                   ordered;

  // Held event and output register
  logic       held_valid;
  logic [2:0] held_src;
  logic       held_combo;
  logic [2:0] held_code;

  logic [BTN_W-1:0] bi;
  logic             pressed;
  logic [7:0]       cnt_inc;
  logic             change;
  logic [TIME_BITS-1:0] gap;
  logic [2:0]       click_next;
  logic [7:0]       long_dec;
  logic [15:0]      entry;
  logic [1:0]       num;
  logic [2:0]       key_sel;
  logic [NUM_BUTTONS-1:0] kmask;
  logic [TIME_BITS-1:0]   t_key;
  logic             new_ev;
  logic [2:0]       new_src;
  logic             new_combo;
  logic [2:0]       new_code;
  logic             load_out;
  logic             sim_ok;

  assign bi      = cmd.btn_idx;
  assign pressed = (levels[bi] == active_high);
  assign cnt_inc = (deb_count[bi] == 8'hFF) ? 8'hFF : deb_count[bi] + 8'd1;
  assign change  = (deb_level[bi] != pressed) && (cnt_inc > debounce_limit);
  assign gap     = tick - release_time[bi];
  assign long_dec = long_count[bi] - 8'd1;

  always_comb begin
    if (gap <= TIME_BITS'(click_gap)) begin
      click_next = (click_count[bi] < 3'd4) ? click_count[bi] + 3'd1 : click_count[bi];
    end else begin
      click_next = 3'd1;
    end
  end

  // Decode the current combo entry
  assign entry = combo_table[16*cmd.cmb_idx +: 16];
  assign num   = entry[3:2];
  always_comb begin
    case (cmd.key_idx)
      2'd0:    key_sel = entry[6:4];
      2'd1:    key_sel = entry[9:7];
      default: key_sel = entry[12:10];
    endcase
    kmask = '0;
    if (num >= 2'd1) kmask[entry[6:4]]   = 1'b1;
    if (num >= 2'd2) kmask[entry[9:7]]   = 1'b1;
    if (num >= 2'd3) kmask[entry[12:10]] = 1'b1;
  end
  assign t_key  = press_time[key_sel[BTN_W-1:0]];
  assign sim_ok = (num >= 2'd2) && ((t_hi - t_lo) <= TIME_BITS'(combo_gap));

  // Status to the controller
  always_comb begin
    sts.btn_en      = enable_mask[bi];
    sts.skip_scan   = (pressed_mask & (pressed_mask - 1'b1)) == '0;
    sts.entry_match = entry[0] && (num != 2'd0) && (pressed_mask == kmask);
    sts.key_last    = (cmd.key_idx == num - 2'd1);
    sts.seq_fail    = entry[1] && !ordered;
    sts.out_free    = !out_valid || out_ready;
  end

  // Pick the event of this step
  always_comb begin
    new_ev    = 1'b0;
    new_src   = 3'(bi);
    new_combo = 1'b0;
    new_code  = EV_PRESS;
    if (cmd.deb_step && change) begin
      if (pressed) begin
        new_ev = 1'b1;
      end else begin
        new_ev = (click_next != 3'd4);
        case (click_next)
          3'd1:    new_code = EV_RELEASE;
          3'd2:    new_code = EV_DOUBLE;
          default: new_code = EV_TRIPLE;
        endcase
      end
    end else if (cmd.long_step) begin
      new_ev   = (long_count[bi] != 8'd0) && deb_level[bi] && (long_dec == 8'd0);
      new_code = EV_LONG;
    end else if (cmd.eval_step) begin
      new_ev    = entry[1] ? ordered : sim_ok;
      new_src   = 3'(cmd.cmb_idx);
      new_combo = 1'b1;
      new_code  = EV_COMBO;
    end
  end

  assign load_out = (cmd.flush && held_valid) || (new_ev && held_valid);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask       <= '0;
      active_high       <= 1'b0;
      debounce_limit    <= 8'd2;
      long_press_table  <= '0;
      long_repeat_table <= '0;
      click_gap         <= 16'd30;
      combo_gap         <= 16'd5;
      combo_table       <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ENABLE:      enable_mask       <= cfg_data[NUM_BUTTONS-1:0];
        REG_ACTIVE_HIGH: active_high       <= cfg_data[0];
        REG_DEBOUNCE:    debounce_limit    <= cfg_data[7:0];
        REG_LONG_PRESS:  long_press_table  <= cfg_data;
        REG_LONG_REPEAT: long_repeat_table <= cfg_data;
        REG_CLICK_GAP:   click_gap         <= cfg_data[15:0];
        REG_COMBO_GAP:   combo_gap         <= cfg_data[15:0];
        REG_COMBO_TABLE: combo_table       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Tick, button and combo state
  always_ff @(posedge clk) begin
    if (rst) begin
      tick         <= '0;
      deb_level    <= '0;
      pressed_mask <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        deb_count[i]    <= '0;
        long_count[i]   <= '0;
        click_count[i]  <= '0;
        press_time[i]   <= '0;
        release_time[i] <= '0;
      end
    end else begin
      if (cmd.accept) begin
        tick   <= tick + 1'b1;
        levels <= button_levels;
      end
      if (cmd.deb_step) begin
        if (deb_level[bi] == pressed) begin
          deb_count[bi] <= '0;
        end else if (!change) begin
          deb_count[bi] <= cnt_inc;
        end else begin
          deb_level[bi]  <= pressed;
          deb_count[bi]  <= '0;
          long_count[bi] <= long_press_table[8*bi +: 8];
          if (pressed) begin
            pressed_mask[bi] <= 1'b1;
            press_time[bi]   <= tick;
          end else begin
            pressed_mask[bi] <= 1'b0;
            click_count[bi]  <= click_next;
            release_time[bi] <= tick;
          end
        end
      end
      if (cmd.long_step && long_count[bi] != 8'd0 && deb_level[bi]) begin
        long_count[bi] <= (long_dec == 8'd0) ? long_repeat_table[8*bi +: 8] : long_dec;
      end
      if (cmd.entry_step && sts.entry_match) begin
        pressed_mask <= pressed_mask & ~kmask;
      end
    end
  end

  // Accumulate key press times of a matched combo
  always_ff @(posedge clk) begin
    if (cmd.key_step) begin
      t_prev <= t_key;
      if (cmd.key_idx == 2'd0) begin
        t_lo    <= t_key;
        t_hi    <= t_key;
        ordered <= 1'b1;
      end else begin
        if (t_key < t_lo) t_lo <= t_key;
        if (t_key > t_hi) t_hi <= t_key;
        ordered <= ordered && (t_prev < t_key);
      end
    end
  end

  // Hold one event back so the final one of the tick can be flagged
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.flush) begin
        held_valid <= 1'b0;
      end else if (new_ev) begin
        held_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      source_index <= held_src;
      is_combo     <= held_combo;
      event_code   <= held_code;
      last_event   <= cmd.flush;
    end
    if (new_ev) begin
      held_src   <= new_src;
      held_combo <= new_combo;
      held_code  <= new_code;
    end
  end

  a_flush_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |=> !held_valid)
    else $error("held event survived the end of the tick");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !load_out)
    else $error("pending result overwritten");
  a_tick_step: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> tick == $past(tick) + TIME_BITS'(1))
    else $error("tick counter did not advance by one");

endmodule

[sv/button_event_detector.sv]
// Top level of the button event detector: sequencer plus datapath.
// Depends on bed_pkg, bed_ctrl and bed_dp.
//
//   channel  | handshake             | payload
//   input    | in_valid / in_ready   | button_levels[7:0]
//   result   | out_valid / out_ready | source_index, is_combo, event_code, last_event
//   config   | cfg_valid / cfg_ready | cfg_index[2:0], cfg_data[63:0]
//
// One poll tick runs an accept step, a debounce step per button and a long-press step
// per enabled button, a scan start, then (only with two or more buttons held) a walk
// over the combo entries with key-time steps and an evaluation for each combo that
// matches, and a flush. Unless stalled, the sequencer visits one button phase, combo
// entry or key time per cycle. A stalled result output holds the sequencer at its next
// button, combo evaluation or flush step. Reset is synchronous; config writes are taken every cycle.
module button_event_detector
  import bed_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  button_levels,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  source_index,
  output logic        is_combo,
  output logic [2:0]  event_code,
  output logic        last_event,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  bed_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bed_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .button_levels (button_levels),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .source_index  (source_index),
    .is_combo      (is_combo),
    .event_code    (event_code),
    .last_event    (last_event)
  );

endmodule
